[sv/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants of the sample set statistics block.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned MEAN_W      = 24;
  localparam int unsigned VAR_W       = 38;
  localparam int unsigned SD_W        = 23;
  localparam int unsigned CNT_W       = 11;
  // variance scaled by 2^16; population variance of 16-bit samples is below 2^30 + 1
  localparam int unsigned VAR16_W     = 47;
  localparam int unsigned SQRT_STEPS  = 24;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 136;

  // first member lands in the highest bits
  typedef struct packed {
    logic                       overflow;
    logic [CNT_W-1:0]           sample_count;
    logic [SD_W-1:0]            std_dev;
    logic [VAR_W-1:0]           variance;
    logic signed [MEAN_W-1:0]   mean;
    logic signed [SAMPLE_W-1:0] largest;
    logic signed [SAMPLE_W-1:0] smallest;
  } result_t;

  localparam int unsigned RES_W = $bits(result_t);

endpackage

[sv/sss_accum.sv]
// ----------------------------------------------------------------------------
// sss_accum
// Running count, minimum, maximum, sum and sum of squares of the current set.
// ----------------------------------------------------------------------------
module sss_accum #(
  parameter int unsigned MAX_COUNT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                take_i,
  input  logic [sss_pkg::SAMPLE_W-1:0]        sample_i,
  input  logic                                last_i,
  output logic [$clog2(MAX_COUNT+1)-1:0]      n_o,
  output logic [$clog2(MAX_COUNT+1)+15:0]     sum_o,
  output logic [$clog2(MAX_COUNT+1)+30:0]     sumsq_o,
  output logic [sss_pkg::SAMPLE_W-1:0]        min_o,
  output logic [sss_pkg::SAMPLE_W-1:0]        max_o,
  output logic                                dropped_o
);

  localparam int unsigned CW = $clog2(MAX_COUNT+1);
  localparam int unsigned SW = CW + 16;
  localparam int unsigned QW = CW + 31;
  localparam logic [CW-1:0] MAX_N = CW'(MAX_COUNT);
  localparam logic [sss_pkg::SAMPLE_W-1:0] MIN_RST = 16'h7fff;
  localparam logic [sss_pkg::SAMPLE_W-1:0] MAX_RST = 16'h8000;

  logic [CW-1:0]                   count_q, count_d;
  logic [sss_pkg::SAMPLE_W-1:0]    min_q, min_d, max_q, max_d;
  logic [SW-1:0]                   sum_q, sum_d;
  logic [QW-1:0]                   sumsq_q, sumsq_d;
  logic                            drop_q, drop_d;
  logic signed [31:0]              sq;

  assign sq = $signed(sample_i) * $signed(sample_i);

  always_comb begin
    count_d = count_q;
    min_d   = min_q;
    max_d   = max_q;
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    drop_d  = drop_q;
    if (count_q < MAX_N) begin
      count_d = count_q + CW'(1);
      if ($signed(sample_i) < $signed(min_q)) begin
        min_d = sample_i;
      end
      if ($signed(sample_i) > $signed(max_q)) begin
        max_d = sample_i;
      end
      sum_d   = sum_q + SW'($signed(sample_i));
      sumsq_d = sumsq_q + QW'($unsigned(sq));
    end else begin
      drop_d = 1'b1;
    end
  end

  assign n_o       = count_d;
  assign sum_o     = sum_d;
  assign sumsq_o   = sumsq_d;
  assign min_o     = min_d;
  assign max_o     = max_d;
  assign dropped_o = drop_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= MIN_RST;
      max_q   <= MAX_RST;
      sum_q   <= '0;
      sumsq_q <= '0;
      drop_q  <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        count_q <= '0;
        min_q   <= MIN_RST;
        max_q   <= MAX_RST;
        sum_q   <= '0;
        sumsq_q <= '0;
        drop_q  <= 1'b0;
      end else begin
        count_q <= count_d;
        min_q   <= min_d;
        max_q   <= max_d;
        sum_q   <= sum_d;
        sumsq_q <= sumsq_d;
        drop_q  <= drop_d;
      end
    end
  end

endmodule

[sv/sss_solver.sv]
// ----------------------------------------------------------------------------
// sss_solver
// Closing arithmetic of a set: n^2, n*sumsq - sum^2, two long divisions and an
// integer square root, all on one shared add/subtract unit under a sequencer.
// ----------------------------------------------------------------------------
module sss_solver #(
  parameter int unsigned MAX_COUNT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [$clog2(MAX_COUNT+1)-1:0]      n_i,
  input  logic [$clog2(MAX_COUNT+1)+15:0]     sum_i,
  input  logic [$clog2(MAX_COUNT+1)+30:0]     sumsq_i,
  input  logic [sss_pkg::SAMPLE_W-1:0]        min_i,
  input  logic [sss_pkg::SAMPLE_W-1:0]        max_i,
  input  logic                                dropped_i,
  output logic                                busy_o,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output sss_pkg::result_t                    res_o
);

  localparam int unsigned CW   = $clog2(MAX_COUNT+1);
  localparam int unsigned SW   = CW + 16;
  localparam int unsigned QW   = CW + 31;
  localparam int unsigned N2W  = 2 * CW;
  localparam int unsigned DW   = CW + QW;
  localparam int unsigned AW   = DW + 16;
  localparam int unsigned CNTW = $clog2(AW + 1);
  localparam int unsigned MW   = sss_pkg::MEAN_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NSQ,
    S_SUMSQ,
    S_NSUMSQ,
    S_DIVV,
    S_DIVM,
    S_SQRT,
    S_DONE
  } state_e;

  state_e                         st_q, st_d;
  logic [AW-1:0]                  acc_q, acc_d;
  logic [AW-1:0]                  mcand_q, mcand_d;
  logic [AW-1:0]                  mplier_q, mplier_d;
  logic [N2W-1:0]                 dsr_q, dsr_d;
  logic [CNTW-1:0]                cnt_q, cnt_d;
  logic [CW-1:0]                  n_q, n_d;
  logic [SW-1:0]                  abs_q, abs_d;
  logic                           neg_q, neg_d;
  logic [QW-1:0]                  sumsq_q, sumsq_d;
  logic [sss_pkg::SAMPLE_W-1:0]   min_q, min_d, max_q, max_d;
  logic                           drop_q, drop_d;
  logic [sss_pkg::VAR16_W-1:0]    var16_q, var16_d;
  logic [MW-1:0]                  mean_q, mean_d;

  // shared unit
  logic [AW-1:0]                  add_a, add_b;
  logic                           add_sub;
  logic [AW:0]                    add_y;
  logic                           add_ok;
  logic [AW-1:0]                  div_sh;
  logic [MW-1:0]                  mean_mag;

  assign add_y  = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (AW+1)'(add_sub);
  assign add_ok = add_y[AW];
  assign div_sh = {acc_q[AW-2:0], mcand_q[AW-1]};
  // a negative mean with a remainder rounds away from zero to floor
  assign mean_mag = mcand_q[MW-1:0] + MW'(neg_q && (acc_q != '0));

  always_comb begin
    add_sub = 1'b0;
    add_a   = acc_q;
    add_b   = mcand_q;
    unique case (st_q)
      S_SUMSQ: add_sub = 1'b1;
      S_DIVV, S_DIVM: begin
        add_sub = 1'b1;
        add_a   = div_sh;
        add_b   = AW'(dsr_q);
      end
      S_SQRT: begin
        add_sub = 1'b1;
        add_b   = mcand_q | mplier_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d     = st_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    dsr_d    = dsr_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    abs_d    = abs_q;
    neg_d    = neg_q;
    sumsq_d  = sumsq_q;
    min_d    = min_q;
    max_d    = max_q;
    drop_d   = drop_q;
    var16_d  = var16_q;
    mean_d   = mean_q;
    unique case (st_q)
      S_IDLE: begin
        if (start_i) begin
          n_d      = n_i;
          neg_d    = sum_i[SW-1];
          abs_d    = sum_i[SW-1] ? (~sum_i + SW'(1)) : sum_i;
          sumsq_d  = sumsq_i;
          min_d    = min_i;
          max_d    = max_i;
          drop_d   = dropped_i;
          acc_d    = '0;
          mcand_d  = AW'(n_i);
          mplier_d = AW'(n_i);
          st_d     = S_NSQ;
        end
      end
      S_NSQ, S_SUMSQ, S_NSUMSQ: begin
        if (mplier_q == '0) begin
          unique case (st_q)
            S_NSQ: begin
              dsr_d    = acc_q[N2W-1:0];
              acc_d    = '0;
              mcand_d  = AW'(abs_q);
              mplier_d = AW'(abs_q);
              st_d     = S_SUMSQ;
            end
            S_SUMSQ: begin
              mcand_d  = AW'(sumsq_q);
              mplier_d = AW'(n_q);
              st_d     = S_NSUMSQ;
            end
            default: begin
              mcand_d = acc_q << 16;
              acc_d   = '0;
              cnt_d   = CNTW'(AW);
              st_d    = S_DIVV;
            end
          endcase
        end else begin
          if (mplier_q[0]) begin
            acc_d = add_y[AW-1:0];
          end
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end
      end
      S_DIVV, S_DIVM: begin
        if (cnt_q == '0) begin
          if (st_q == S_DIVV) begin
            var16_d = mcand_q[sss_pkg::VAR16_W-1:0];
            mcand_d = AW'(abs_q) << 8;
            acc_d   = '0;
            dsr_d   = N2W'(n_q);
            cnt_d   = CNTW'(AW);
            st_d    = S_DIVM;
          end else begin
            mean_d   = neg_q ? ((~mean_mag) + MW'(1)) : mean_mag;
            acc_d    = AW'(var16_q);
            mcand_d  = '0;
            mplier_d = AW'(1) << (sss_pkg::VAR16_W - 1);
            cnt_d    = CNTW'(sss_pkg::SQRT_STEPS);
            st_d     = S_SQRT;
          end
        end else begin
          acc_d   = add_ok ? add_y[AW-1:0] : div_sh;
          mcand_d = {mcand_q[AW-2:0], add_ok};
          cnt_d   = cnt_q - CNTW'(1);
        end
      end
      S_SQRT: begin
        if (cnt_q == '0) begin
          st_d = S_DONE;
        end else begin
          if (add_ok) begin
            acc_d   = add_y[AW-1:0];
            mcand_d = (mcand_q >> 1) | mplier_q;
          end else begin
            mcand_d = mcand_q >> 1;
          end
          mplier_d = mplier_q >> 2;
          cnt_d    = cnt_q - CNTW'(1);
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q     <= st_d;
      acc_q    <= acc_d;
      mcand_q  <= mcand_d;
      mplier_q <= mplier_d;
      dsr_q    <= dsr_d;
      cnt_q    <= cnt_d;
      n_q      <= n_d;
      abs_q    <= abs_d;
      neg_q    <= neg_d;
      sumsq_q  <= sumsq_d;
      min_q    <= min_d;
      max_q    <= max_d;
      drop_q   <= drop_d;
      var16_q  <= var16_d;
      mean_q   <= mean_d;
    end
  end

  assign busy_o      = (st_q != S_IDLE);
  assign res_valid_o = (st_q == S_DONE);

  always_comb begin
    res_o.smallest     = min_q;
    res_o.largest      = max_q;
    res_o.mean         = mean_q;
    res_o.variance     = var16_q[sss_pkg::VAR_W+7:8];
    res_o.std_dev      = mcand_q[sss_pkg::SD_W-1:0];
    res_o.sample_count = sss_pkg::CNT_W'(n_q);
    res_o.overflow     = drop_q;
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> st_q == S_IDLE)
    else $error("set closed while solver busy");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIVV || st_q == S_DIVM) |-> (dsr_q != '0 && acc_q < AW'(dsr_q)))
    else $error("division remainder out of range");

  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_SQRT |-> $onehot0(mplier_q))
    else $error("square root bit not a single bit");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DONE && !res_ready_i) |=> (st_q == S_DONE && $stable(mean_q)))
    else $error("result lost before it was taken");

endmodule

[sv/sample_set_statistics.sv]
// ----------------------------------------------------------------------------
// sample_set_statistics
// Min, max, mean, population variance and standard deviation per sample set.
// ----------------------------------------------------------------------------
// Samples enter on the s_axis channel, one item per cycle; tlast marks the
// final sample of a set. That item closes the set and the block drops
// s_axis_tready while one shared add/subtract unit works out n^2,
// n*sumsq - sum^2, the variance and mean divisions (one quotient bit a cycle)
// and the square root (one result bit a cycle). The shared unit is AW bits wide,
// with CW = clog2(MAX_COUNT+1) and AW = 2*CW + 47. The result leaves on
// m_axis from an output register, so the next set's samples are taken while
// a result waits; if the receiver still stalls when the following set closes,
// the solver holds its result and s_axis stays stalled. Samples beyond
// MAX_COUNT in a set are ignored and flagged.
// Reset clears the running set and empties the output register.
// ----------------------------------------------------------------------------
module sample_set_statistics #(
  parameter int unsigned MAX_COUNT = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sss_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [15:0] sample
  input  logic                               s_axis_tlast,  // last
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] smallest, [31:16] largest, [55:32] mean, [93:56] variance,
  // [116:94] std_dev, [127:117] sample_count, [128] overflow, rest zero
  output logic [sss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned CW = $clog2(MAX_COUNT+1);
  localparam int unsigned SW = CW + 16;
  localparam int unsigned QW = CW + 31;

  logic                              busy;
  logic                              take;
  logic                              close;
  logic [CW-1:0]                     acc_n;
  logic [SW-1:0]                     acc_sum;
  logic [QW-1:0]                     acc_sumsq;
  logic [sss_pkg::SAMPLE_W-1:0]      acc_min, acc_max;
  logic                              acc_drop;
  logic                              res_valid, res_ready;
  sss_pkg::result_t                  res;
  logic                              out_valid_q;
  logic [sss_pkg::OUT_TDATA_W-1:0]   out_data_q;

  assign s_axis_tready = !busy;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign close         = take && s_axis_tlast;

  sss_accum #(
    .MAX_COUNT (MAX_COUNT)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .sample_i  (s_axis_tdata[sss_pkg::SAMPLE_W-1:0]),
    .last_i    (s_axis_tlast),
    .n_o       (acc_n),
    .sum_o     (acc_sum),
    .sumsq_o   (acc_sumsq),
    .min_o     (acc_min),
    .max_o     (acc_max),
    .dropped_o (acc_drop)
  );

  sss_solver #(
    .MAX_COUNT (MAX_COUNT)
  ) u_solver (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (close),
    .n_i         (acc_n),
    .sum_i       (acc_sum),
    .sumsq_i     (acc_sumsq),
    .min_i       (acc_min),
    .max_i       (acc_max),
    .dropped_i   (acc_drop),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= {(sss_pkg::OUT_TDATA_W - sss_pkg::RES_W)'(0), res};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
